@@ design/scbh_pkg.sv @@
// ----------------------------------------------------------------------------
// scbh_pkg
// Shared constants for the sequenced chunk history buffer.
// ----------------------------------------------------------------------------
package scbh_pkg;

    localparam int DEF_STORE_BYTES = 256;
    localparam int DEF_MAX_CHUNKS  = 256;
    localparam int DEF_WORD_BYTES  = 8;

    // most result words one query returns
    localparam int MAX_RESULTS = 32;

    localparam logic [8:0] BUDGET_RESET = 9'd256;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_TAIL   = 2'd1;
    localparam logic [1:0] KIND_SLICE  = 2'd2;

endpackage

@@ design/scbh_ram.sv @@
// ----------------------------------------------------------------------------
// scbh_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scbh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ design/sequenced_chunk_history_buffer.sv @@
// ----------------------------------------------------------------------------
// sequenced_chunk_history_buffer
// Byte history of numbered chunks kept under a byte budget, with tail and
// from-sequence queries answered in words.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+-----------
//  input   | in_valid, in_stall, kind .. start_seq     | into block
//  output  | out_valid, out_stall, data_word .. seq    | out of block
//  config  | cfg_wr_en, cfg_wr_data (byte_budget)      | into block
//
//  An append evicts oldest chunks until its byte fits; a completed chunk is
//  then stored and oldest chunks evicted while over budget. A query walks
//  the chunks, then reads each byte via the byte RAM's one read port and
//  sends each word. The next item is taken when the sequencer is back in
//  idle. Reset clears all control state; the RAMs hold no reset and are read
//  only where written. A stalled result holds the sequencer in its send
//  state; a waiting result does not stop the next transfer in.
//
module sequenced_chunk_history_buffer
#(
    parameter int STORE_BYTES = scbh_pkg::DEF_STORE_BYTES,
    parameter int MAX_CHUNKS  = scbh_pkg::DEF_MAX_CHUNKS,
    parameter int WORD_BYTES  = scbh_pkg::DEF_WORD_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        chunk_end,
    input  logic [8:0]  tail_limit,
    input  logic [63:0] start_seq,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] data_word,
    output logic [3:0]  valid_bytes,
    output logic [63:0] first_seq,
    output logic [63:0] last_seq,
    output logic        is_empty,
    output logic        is_last,
    output logic [8:0]  stored_bytes,
    output logic [63:0] upcoming_seq
);

    import scbh_pkg::*;

    localparam int AW   = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int TW   = $clog2(STORE_BYTES + 1);
    localparam int CAW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CW   = $clog2(MAX_CHUNKS + 1);
    localparam int EW   = AW + TW + 64;
    localparam int MAXN = MAX_RESULTS * WORD_BYTES;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APP_CHK,
        ST_APP_DROP,
        ST_CMP_FULL,
        ST_CMP_FDROP,
        ST_CMP_STORE,
        ST_EVICT_CHK,
        ST_EVICT_DROP,
        ST_Q_BASE,
        ST_Q_NEWEST,
        ST_Q_LAST,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_BYTE_RD,
        ST_BYTE_CAP,
        ST_SEND
    } state_t;

    // empty answers reuse ST_SEND with this flag set
    state_t           state_reg;
    logic             send_empty_reg;
    logic [8:0]       budget_reg;
    logic [CAW-1:0]   oldest_reg;
    logic [CW-1:0]    count_reg;
    logic [TW-1:0]    total_reg;
    logic [AW-1:0]    wpos_reg;
    logic [TW-1:0]    open_reg;
    logic [63:0]      seq_reg;

    logic [7:0]       byte_reg;
    logic             end_reg;
    logic             tail_reg;
    logic [63:0]      want_reg;
    logic [TW-1:0]    kept_reg;
    logic [TW-1:0]    ebud_reg;
    logic [TW-1:0]    from_reg;
    logic [TW-1:0]    n_reg;
    logic [TW-1:0]    acc_reg;
    logic [CW-1:0]    idx_reg;
    logic [AW-1:0]    base_reg;
    logic [63:0]      newest_reg;
    logic [63:0]      first_reg;
    logic [AW-1:0]    pos_reg;
    logic [TW-1:0]    rem_reg;
    logic [3:0]       lane_reg;
    logic [63:0]      word_reg;

    logic             out_valid_reg;
    logic [63:0]      data_word_reg;
    logic [3:0]       valid_bytes_reg;
    logic [63:0]      first_seq_reg;
    logic [63:0]      last_seq_reg;
    logic             is_empty_reg;
    logic             is_last_reg;
    logic [8:0]       stored_bytes_reg;
    logic [63:0]      upcoming_seq_reg;

    // RAM ports
    logic             byte_we;
    logic [7:0]       byte_rdata;
    logic             ent_we;
    logic [CAW-1:0]   ent_waddr;
    logic [EW-1:0]    ent_wdata;
    logic [CAW-1:0]   ent_raddr;
    logic [EW-1:0]    ent_rdata;
    logic [63:0]      rd_seq;
    logic [TW-1:0]    rd_len;
    logic [AW-1:0]    rd_start;

    function automatic logic [CAW-1:0] slot_of(input logic [CAW-1:0] base,
                                               input logic [CW-1:0]  off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(MAX_CHUNKS))
        begin
            s = s - (CW+1)'(MAX_CHUNKS);
        end
        return s[CAW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [TW-1:0] b);
        logic [TW:0] s;
        s = (TW+1)'(a) + (TW+1)'(b);
        if (s >= (TW+1)'(STORE_BYTES))
        begin
            s = s - (TW+1)'(STORE_BYTES);
        end
        return s[AW-1:0];
    endfunction

    assign rd_seq   = ent_rdata[63:0];
    assign rd_len   = ent_rdata[64 +: TW];
    assign rd_start = ent_rdata[64+TW +: AW];

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic [TW:0]    fill_sum;
    logic           need_drop;
    logic [AW-1:0]  wpos_inc;
    logic [TW-1:0]  open_new;
    logic [31:0]    eff32;
    logic [TW-1:0]  eff_budget;
    logic [TW-1:0]  kept_new;
    logic [TW:0]    start_t;
    logic [AW-1:0]  chunk_start_pos;
    logic [CAW-1:0] oldest_inc;
    logic           out_free;
    logic [TW:0]    acc_len;
    logic [TW-1:0]  tail_n;
    logic [TW-1:0]  seq_n;
    logic [TW-1:0]  sel_from;
    logic [TW-1:0]  sel_n;
    logic [TW-1:0]  capped_n;
    logic           walk_hit;

    assign fill_sum  = (TW+1)'(total_reg) + (TW+1)'(open_reg) + (TW+1)'(1);
    assign need_drop = (count_reg != '0) && (fill_sum > (TW+1)'(STORE_BYTES));
    assign wpos_inc  = (wpos_reg == AW'(STORE_BYTES - 1)) ? '0 : wpos_reg + AW'(1);
    assign open_new  = (open_reg < TW'(STORE_BYTES)) ? open_reg + TW'(1) : open_reg;

    always_comb
    begin
        eff32 = 32'(budget_reg);
        if (eff32 == 32'd0)
        begin
            eff32 = 32'd1;
        end
        if (eff32 > 32'(STORE_BYTES))
        begin
            eff32 = 32'(STORE_BYTES);
        end
    end

    assign eff_budget = TW'(eff32);
    assign kept_new   = (open_new < eff_budget) ? open_new : eff_budget;

    // first byte of the kept tail of the chunk just closed
    assign start_t = (TW+1)'(wpos_reg) + (TW+1)'(STORE_BYTES) - (TW+1)'(kept_reg);
    assign chunk_start_pos = (start_t >= (TW+1)'(STORE_BYTES)) ?
                             AW'(start_t - (TW+1)'(STORE_BYTES)) : AW'(start_t);

    assign oldest_inc = (oldest_reg == CAW'(MAX_CHUNKS - 1)) ? '0 : oldest_reg + CAW'(1);
    assign out_free   = !out_valid_reg || !out_stall;

    assign acc_len  = (TW+1)'(acc_reg) + (TW+1)'(rd_len);
    assign tail_n   = (32'(tail_limit) < 32'(total_reg)) ? TW'(tail_limit) : total_reg;
    assign seq_n    = total_reg - acc_reg;
    assign walk_hit = tail_reg ? ((TW+1)'(from_reg) < acc_len) : (rd_seq >= want_reg);
    assign sel_from = tail_reg ? from_reg : acc_reg;
    assign sel_n    = tail_reg ? n_reg : seq_n;
    assign capped_n = (32'(sel_n) > 32'(MAXN)) ? TW'(MAXN) : sel_n;

    // ------------------------------------------------------------------
    // RAM hookup
    // ------------------------------------------------------------------
    assign byte_we   = (state_reg == ST_APP_CHK) && !need_drop;
    assign ent_we    = (state_reg == ST_CMP_STORE);
    assign ent_waddr = slot_of(oldest_reg, count_reg);
    assign ent_wdata = {chunk_start_pos, kept_reg, seq_reg};

    always_comb
    begin
        unique case (state_reg)
            ST_Q_NEWEST: ent_raddr = slot_of(oldest_reg, count_reg - CW'(1));
            ST_WALK_RD:  ent_raddr = slot_of(oldest_reg, idx_reg);
            default:     ent_raddr = oldest_reg;
        endcase
    end

    scbh_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (wpos_reg),
        .wdata (byte_reg),
        .raddr (pos_reg),
        .rdata (byte_rdata)
    );

    scbh_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_CHUNKS),
        .AW    (CAW)
    ) u_chunk_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            send_empty_reg   <= 1'b0;
            budget_reg       <= BUDGET_RESET;
            oldest_reg       <= '0;
            count_reg        <= '0;
            total_reg        <= '0;
            wpos_reg         <= '0;
            open_reg         <= '0;
            seq_reg          <= '0;
            byte_reg         <= '0;
            end_reg          <= 1'b0;
            tail_reg         <= 1'b0;
            want_reg         <= '0;
            kept_reg         <= '0;
            ebud_reg         <= '0;
            from_reg         <= '0;
            n_reg            <= '0;
            acc_reg          <= '0;
            idx_reg          <= '0;
            base_reg         <= '0;
            newest_reg       <= '0;
            first_reg        <= '0;
            pos_reg          <= '0;
            rem_reg          <= '0;
            lane_reg         <= '0;
            word_reg         <= '0;
            out_valid_reg    <= 1'b0;
            data_word_reg    <= '0;
            valid_bytes_reg  <= '0;
            first_seq_reg    <= '0;
            last_seq_reg     <= '0;
            is_empty_reg     <= 1'b0;
            is_last_reg      <= 1'b0;
            stored_bytes_reg <= '0;
            upcoming_seq_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                budget_reg <= cfg_wr_data;
            end

            // drop the result once the consumer takes it; the send state
            // reloads the register itself
            if (out_valid_reg && !out_stall && state_reg != ST_SEND)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg) inside
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        byte_reg <= data_byte;
                        end_reg  <= chunk_end;
                        want_reg <= start_seq;
                        tail_reg <= (kind == KIND_TAIL);
                        case (kind)
                            KIND_APPEND:
                            begin
                                state_reg <= ST_APP_CHK;
                            end
                            KIND_TAIL:
                            begin
                                n_reg    <= tail_n;
                                from_reg <= total_reg - tail_n;
                                if (count_reg == '0 || tail_limit == '0 || total_reg == '0)
                                begin
                                    send_empty_reg <= 1'b1;
                                    state_reg      <= ST_SEND;
                                end
                                else
                                begin
                                    state_reg <= ST_Q_BASE;
                                end
                            end
                            KIND_SLICE:
                            begin
                                if (count_reg == '0)
                                begin
                                    send_empty_reg <= 1'b1;
                                    state_reg      <= ST_SEND;
                                end
                                else
                                begin
                                    state_reg <= ST_Q_BASE;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_APP_CHK:
                begin
                    // make room for the open chunk before writing its byte
                    if (need_drop)
                    begin
                        state_reg <= ST_APP_DROP;
                    end
                    else
                    begin
                        wpos_reg <= wpos_inc;
                        open_reg <= open_new;
                        kept_reg <= kept_new;
                        ebud_reg <= eff_budget;
                        state_reg <= end_reg ? ST_CMP_FULL : ST_IDLE;
                    end
                end

                ST_APP_DROP, ST_CMP_FDROP, ST_EVICT_DROP:
                begin
                    total_reg  <= total_reg - rd_len;
                    oldest_reg <= oldest_inc;
                    count_reg  <= count_reg - CW'(1);
                    unique case (state_reg)
                        ST_APP_DROP:  state_reg <= ST_APP_CHK;
                        ST_CMP_FDROP: state_reg <= ST_CMP_STORE;
                        default:      state_reg <= ST_EVICT_CHK;
                    endcase
                end

                ST_CMP_FULL:
                begin
                    state_reg <= (32'(count_reg) >= 32'(MAX_CHUNKS)) ?
                                 ST_CMP_FDROP : ST_CMP_STORE;
                end

                ST_CMP_STORE:
                begin
                    seq_reg   <= seq_reg + 64'd1;
                    total_reg <= total_reg + kept_reg;
                    count_reg <= count_reg + CW'(1);
                    open_reg  <= '0;
                    state_reg <= ST_EVICT_CHK;
                end

                ST_EVICT_CHK:
                begin
                    state_reg <= (total_reg > ebud_reg && count_reg != '0) ?
                                 ST_EVICT_DROP : ST_IDLE;
                end

                ST_Q_BASE:
                begin
                    state_reg <= ST_Q_NEWEST;
                end

                ST_Q_NEWEST:
                begin
                    base_reg  <= rd_start;
                    state_reg <= ST_Q_LAST;
                end

                ST_Q_LAST:
                begin
                    newest_reg <= rd_seq;
                    idx_reg    <= '0;
                    acc_reg    <= '0;
                    state_reg  <= ST_WALK_RD;
                end

                ST_WALK_RD:
                begin
                    state_reg <= ST_WALK_CHK;
                end

                ST_WALK_CHK:
                begin
                    if (walk_hit)
                    begin
                        first_reg <= rd_seq;
                        pos_reg   <= wrap_add(base_reg, sel_from);
                        rem_reg   <= capped_n;
                        lane_reg  <= '0;
                        word_reg  <= '0;
                        if (sel_n == '0)
                        begin
                            send_empty_reg <= 1'b1;
                            state_reg      <= ST_SEND;
                        end
                        else
                        begin
                            state_reg <= ST_BYTE_RD;
                        end
                    end
                    else
                    begin
                        acc_reg <= acc_len[TW-1:0];
                        idx_reg <= idx_reg + CW'(1);
                        if (idx_reg + CW'(1) == count_reg)
                        begin
                            send_empty_reg <= 1'b1;
                            state_reg      <= ST_SEND;
                        end
                        else
                        begin
                            state_reg <= ST_WALK_RD;
                        end
                    end
                end

                ST_BYTE_RD:
                begin
                    state_reg <= ST_BYTE_CAP;
                end

                ST_BYTE_CAP:
                begin
                    word_reg[lane_reg*8 +: 8] <= byte_rdata;
                    pos_reg  <= wrap_add(pos_reg, TW'(1));
                    lane_reg <= lane_reg + 4'd1;
                    rem_reg  <= rem_reg - TW'(1);
                    if (32'(lane_reg) + 32'd1 == 32'(WORD_BYTES) || rem_reg == TW'(1))
                    begin
                        state_reg <= ST_SEND;
                    end
                    else
                    begin
                        state_reg <= ST_BYTE_RD;
                    end
                end

                ST_SEND:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        stored_bytes_reg <= 9'(total_reg);
                        upcoming_seq_reg <= seq_reg;
                        if (send_empty_reg)
                        begin
                            data_word_reg   <= '0;
                            valid_bytes_reg <= '0;
                            first_seq_reg   <= '0;
                            last_seq_reg    <= '0;
                            is_empty_reg    <= 1'b1;
                            is_last_reg     <= 1'b1;
                            send_empty_reg  <= 1'b0;
                            state_reg       <= ST_IDLE;
                        end
                        else
                        begin
                            data_word_reg   <= word_reg;
                            valid_bytes_reg <= lane_reg;
                            first_seq_reg   <= first_reg;
                            last_seq_reg    <= newest_reg;
                            is_empty_reg    <= 1'b0;
                            is_last_reg     <= (rem_reg == '0);
                            lane_reg        <= '0;
                            word_reg        <= '0;
                            state_reg       <= (rem_reg == '0) ? ST_IDLE : ST_BYTE_RD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign data_word    = data_word_reg;
    assign valid_bytes  = valid_bytes_reg;
    assign first_seq    = first_seq_reg;
    assign last_seq     = last_seq_reg;
    assign is_empty     = is_empty_reg;
    assign is_last      = is_last_reg;
    assign stored_bytes = stored_bytes_reg;
    assign upcoming_seq = upcoming_seq_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_total_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= 32'(STORE_BYTES))
        else $error("history holds more bytes than the store");

    a_count_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_CHUNKS))
        else $error("chunk count exceeds table depth");

    a_no_chunks_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> total_reg == '0)
        else $error("bytes held with no chunk stored");

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> valid_bytes == 4'd0 && is_last && first_seq == 64'd0)
        else $error("empty result carries data");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sequenced chunk history buffer: drives append,
// tail and slice items under random idling and back-pressure, predicts every
// result word and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import scbh_pkg::*;

    localparam int STORE    = 256;
    localparam int CHUNKS   = 256;
    localparam int LANES    = 8;
    // quiet time that covers the slowest query or eviction walk
    localparam int SETTLE   = 1500;
    localparam int WD_LIMIT = 20000;

    // kind code the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // one result word as the block presents it
    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic [63:0] first_seq;
        logic [63:0] last_seq;
        logic        is_empty;
        logic        is_last;
        logic [8:0]  stored_bytes;
        logic [63:0] upcoming_seq;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        chunk_end;
    logic [8:0]  tail_limit;
    logic [63:0] start_seq;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic [63:0] first_seq;
    logic [63:0] last_seq;
    logic        is_empty;
    logic        is_last;
    logic [8:0]  stored_bytes;
    logic [63:0] upcoming_seq;

    sequenced_chunk_history_buffer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .chunk_end    (chunk_end),
        .tail_limit   (tail_limit),
        .start_seq    (start_seq),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_word    (data_word),
        .valid_bytes  (valid_bytes),
        .first_seq    (first_seq),
        .last_seq     (last_seq),
        .is_empty     (is_empty),
        .is_last      (is_last),
        .stored_bytes (stored_bytes),
        .upcoming_seq (upcoming_seq)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the history, updated at every accepted input transfer
    // ------------------------------------------------------------------
    logic [7:0]  hist_mem   [STORE];
    int          ch_start   [CHUNKS];
    int          ch_len     [CHUNKS];
    logic [63:0] ch_seq     [CHUNKS];
    int          ch_oldest;
    int          ch_count;
    int          held_bytes;
    int          wr_ptr;
    int          open_bytes;
    logic [63:0] next_seq;
    int          budget_reg;

    word_t       pending_words[$];
    int          error_count;
    bit          quiet;       // no random idling on either side
    int          hold_left;   // cycles the receiver still holds off
    int          idle_cycles;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int clamp_budget();
        int b;
        b = budget_reg;
        if (b < 1) b = 1;
        if (b > STORE) b = STORE;
        return b;
    endfunction

    function automatic void evict_oldest();
        held_bytes -= ch_len[ch_oldest];
        ch_oldest = (ch_oldest + 1) % CHUNKS;
        ch_count--;
    endfunction

    function automatic void history_append(logic [7:0] b, logic last);
        int kept;
        int slot;
        int lim;
        // drop any completed chunk the open chunk is about to overwrite
        while (ch_count > 0 && held_bytes + open_bytes + 1 > STORE)
            evict_oldest();
        hist_mem[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % STORE;
        if (open_bytes < STORE) open_bytes++;
        if (!last) return;
        lim  = clamp_budget();
        kept = (open_bytes < lim) ? open_bytes : lim;
        if (ch_count >= CHUNKS) evict_oldest();
        slot = (ch_oldest + ch_count) % CHUNKS;
        ch_start[slot] = (wr_ptr + STORE - kept) % STORE;
        ch_len[slot]   = kept;
        ch_seq[slot]   = next_seq;
        next_seq++;
        held_bytes += kept;
        ch_count++;
        open_bytes = 0;
        while (held_bytes > lim && ch_count > 0)
            evict_oldest();
    endfunction

    // append one predicted word behind the ones already waiting
    function automatic void add_expected(word_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic void queue_empty_word();
        word_t w;
        w = '0;
        w.is_empty     = 1'b1;
        w.is_last      = 1'b1;
        w.stored_bytes = held_bytes[8:0];
        w.upcoming_seq = next_seq;
        add_expected(w);
    endfunction

    // queue the words for n bytes starting 'from' bytes past the oldest byte
    function automatic void queue_slice(int from, int n, logic [63:0] first);
        int nwords;
        int base;
        int k;
        word_t w;
        nwords = (n + LANES - 1) / LANES;
        if (nwords > MAX_RESULTS)
        begin
            nwords = MAX_RESULTS;
            n = nwords * LANES;
        end
        base = ch_start[ch_oldest];
        for (int wi = 0; wi < nwords; wi++)
        begin
            w = '0;
            for (int l = 0; l < LANES; l++)
            begin
                k = wi * LANES + l;
                if (k >= n) break;
                w.data_word[8*l +: 8] = hist_mem[(base + from + k) % STORE];
                w.valid_bytes++;
            end
            w.first_seq    = first;
            w.last_seq     = ch_seq[(ch_oldest + ch_count - 1) % CHUNKS];
            w.is_last      = (wi + 1 == nwords);
            w.stored_bytes = held_bytes[8:0];
            w.upcoming_seq = next_seq;
            add_expected(w);
        end
    endfunction

    function automatic void predict_tail(int limit);
        int n;
        int from;
        int acc;
        int slot;
        logic [63:0] first;
        if (ch_count == 0 || limit == 0 || held_bytes == 0)
        begin
            queue_empty_word();
            return;
        end
        n     = (limit < held_bytes) ? limit : held_bytes;
        from  = held_bytes - n;
        acc   = 0;
        first = ch_seq[ch_oldest];
        for (int i = 0; i < ch_count; i++)
        begin
            slot = (ch_oldest + i) % CHUNKS;
            if (from < acc + ch_len[slot])
            begin
                first = ch_seq[slot];
                break;
            end
            acc += ch_len[slot];
        end
        queue_slice(from, n, first);
    endfunction

    function automatic void predict_slice(logic [63:0] want);
        int acc;
        int slot;
        acc = 0;
        for (int i = 0; i < ch_count; i++)
        begin
            slot = (ch_oldest + i) % CHUNKS;
            if (ch_seq[slot] >= want)
            begin
                if (held_bytes - acc == 0) queue_empty_word();
                else queue_slice(acc, held_bytes - acc, ch_seq[slot]);
                return;
            end
            acc += ch_len[slot];
        end
        queue_empty_word();
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: present one item and hold it until the transfer happens
    // ------------------------------------------------------------------
    task automatic send_item(logic [1:0] k, logic [7:0] b, logic e,
                             logic [8:0] lim, logic [63:0] s);
        if (!quiet && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        data_byte  <= b;
        chunk_end  <= e;
        tail_limit <= lim;
        start_seq  <= s;
        do
            @(posedge clk);
        while (in_stall);
        // transfer taken at this edge: advance the shadow copy
        case (k)
            KIND_APPEND: history_append(b, e);
            KIND_TAIL:   predict_tail(lim);
            KIND_SLICE:  predict_slice(s);
            default:     ;
        endcase
    endtask

    task automatic send_chunk(int len);
        for (int i = 0; i < len; i++)
            send_item(KIND_APPEND, 8'($urandom), i == len - 1, '0, 64'($urandom));
    endtask

    task automatic send_tail(logic [8:0] lim);
        send_item(KIND_TAIL, 8'($urandom), 1'($urandom), lim, {$urandom, $urandom});
    endtask

    task automatic send_slice(logic [63:0] s);
        send_item(KIND_SLICE, 8'($urandom), 1'($urandom), 9'($urandom), s);
    endtask

    // drop valid and wait until the block has answered everything
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_budget(logic [8:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        budget_reg = v;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_tail(9'd8);                    // empty history
        send_slice(64'd0);
        send_chunk(1);
        send_tail(9'd0);                    // zero limit gives empty slice
        send_chunk(9);
        send_tail(9'd256);
        send_tail(9'd511);
        send_tail(9'd3);
        send_slice(64'd1);
        send_slice(64'hFFFF_FFFF_FFFF_FFFF); // matches no chunk
        send_item(KIND_UNUSED, 8'hFF, 1'b1, 9'h1FF, '1);
        send_item(KIND_APPEND, 8'h00, 1'b0, '0, '0);
        send_item(KIND_APPEND, 8'hFF, 1'b1, '0, '0);
        send_slice(64'd2);
        send_tail(9'd5);
    endtask

    // queries while a chunk is still open see only completed chunks
    task automatic test_long_chunk();
        send_chunk(10);
        for (int i = 0; i < 40; i++)
        begin
            send_item(KIND_APPEND, 8'($urandom), i == 39, '0, '0);
            if (i == 20) send_tail(9'd256);
        end
        send_tail(9'd256);
        send_slice(64'd0);
    endtask

    task automatic test_backpressure();
        hold_left = 400;
        for (int i = 0; i < 12; i++)
        begin
            send_tail(9'd256);
            send_chunk(2);
        end
    endtask

    task automatic test_pause_until_drained();
        send_chunk(5);
        send_tail(9'd40);
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        send_slice(next_seq - 64'd1);
        send_tail(9'd12);
    endtask

    task automatic random_phase(int items);
        int n;
        int r;
        int len;
        n = 0;
        while (n < items)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20)
                                                  : $urandom_range(1, 6);
                send_chunk(len);
                n += len;
            end
            else if (r < 75)
            begin
                send_tail(($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 64)));
                n++;
            end
            else if (r < 93)
            begin
                if ($urandom_range(0, 3) == 0) send_slice({$urandom, $urandom});
                else send_slice(next_seq - 64'($urandom_range(0, 10)));
                n++;
            end
            else
            begin
                send_item(KIND_UNUSED, 8'($urandom), 1'($urandom), 9'($urandom),
                          {$urandom, $urandom});
                n++;
            end
        end
    endtask

    task automatic test_random_budgets();
        logic [8:0] budgets[7];
        budgets = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd40, 9'd100, 9'd17};
        foreach (budgets[i])
        begin
            write_budget(budgets[i]);
            quiet = (i == 3);
            random_phase(8);
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, forced hold-off, quiet stretches
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 25);
    end

    // compare every output transfer with the oldest predicted word
    always @(posedge clk)
    begin
        word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                report_mismatch("unexpected word", data_word, 64'd0);
            end
            else
            begin
                want = pending_words[0];
                pending_words.delete(0);
                if (data_word !== want.data_word)
                    report_mismatch("data_word", data_word, want.data_word);
                if (valid_bytes !== want.valid_bytes)
                    report_mismatch("valid_bytes", 64'(valid_bytes), 64'(want.valid_bytes));
                if (first_seq !== want.first_seq)
                    report_mismatch("first_seq", first_seq, want.first_seq);
                if (last_seq !== want.last_seq)
                    report_mismatch("last_seq", last_seq, want.last_seq);
                if (is_empty !== want.is_empty)
                    report_mismatch("is_empty", 64'(is_empty), 64'(want.is_empty));
                if (is_last !== want.is_last)
                    report_mismatch("is_last", 64'(is_last), 64'(want.is_last));
                if (stored_bytes !== want.stored_bytes)
                    report_mismatch("stored_bytes", 64'(stored_bytes), 64'(want.stored_bytes));
                if (upcoming_seq !== want.upcoming_seq)
                    report_mismatch("upcoming_seq", upcoming_seq, want.upcoming_seq);
            end
        end
    end

    // end the run if no transfer happens on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        kind        = KIND_APPEND;
        data_byte   = '0;
        chunk_end   = 1'b0;
        tail_limit  = '0;
        start_seq   = '0;
        error_count = 0;
        quiet       = 1'b0;
        hold_left   = 0;
        idle_cycles = 0;
        ch_oldest   = 0;
        ch_count    = 0;
        held_bytes  = 0;
        wr_ptr      = 0;
        open_bytes  = 0;
        next_seq    = '0;
        budget_reg  = BUDGET_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_chunk();
        test_backpressure();
        test_pause_until_drained();
        test_random_budgets();

        drain();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/scbh_pkg.sv
design/scbh_ram.sv
design/sequenced_chunk_history_buffer.sv
dv/tb_top.sv
